/* rtl/adf_pkg.sv */
// Shared types and constants for the advertising data filter.
// Used by adf_parser, advertising_data_filter_top and tb_top; no other dependencies.
package adf_pkg;

  // Storage for the target device name, in bytes
  localparam int unsigned MaxNameBytes = 16;
  localparam int unsigned NameSlots    = 16;

  // AD structure type codes and the fixed service-data field length
  localparam logic [7:0] TypeCompleteName  = 8'h09;
  localparam logic [7:0] TypeServiceData16 = 8'h16;
  localparam logic [7:0] ServiceFieldLen   = 8'd4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgServiceUuid = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNameLength  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNameWord0   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNameWord1   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNameWord2   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNameWord3   = 3'd5;

  // Reset values: UUID 0x3333 and the default 11-byte target name
  localparam logic [15:0] RstServiceUuid = 16'h3333;
  localparam logic [4:0]  RstNameLength  = 5'd11;
  localparam logic [31:0] RstNameWord0   = 32'd1936614771;
  localparam logic [31:0] RstNameWord1   = 32'd1851748975;
  localparam logic [31:0] RstNameWord2   = 32'd6644847;
  localparam logic [31:0] RstNameWord3   = 32'd0;

  // Parser phase
  typedef enum logic [1:0] {
    PhLength,
    PhType,
    PhPayload,
    PhStopped
  } phase_e;

  // Filter settings as seen by the parser
  typedef struct packed {
    logic [15:0]  service_uuid;
    logic [4:0]   name_length;
    logic [127:0] name_bytes;  // byte 0 in bits 7..0
  } filter_cfg_t;

  // Per-packet verdict
  typedef struct packed {
    logic name_hit;
    logic service_hit;
  } filter_hits_t;

endpackage

/* rtl/adf_parser.sv */
// Length-type-value walker for one advertising packet, one byte per item.
// Depends on adf_pkg for the phase enum, type codes and the config struct.
module adf_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           ad_byte_i,
  input  logic                 last_byte_i,
  input  adf_pkg::filter_cfg_t cfg_i,
  output adf_pkg::filter_hits_t hits_o
);
  import adf_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic [7:0] pos_q, pos_d;
  logic       name_eq_q, name_eq_d;
  logic       uuid_eq_q, uuid_eq_d;
  logic       name_seen_q, name_seen_d;
  logic       svc_seen_q, svc_seen_d;

  logic       fin;
  logic [7:0] fin_type;
  logic       fin_name_eq;
  logic       fin_uuid_eq;
  logic       name_byte_ok;
  logic       uuid_byte_ok;
  logic [7:0] name_byte;
  logic [8:0] pos_next_plus1;
  logic       name_len_ok;

  // Stored name byte at the current payload position
  assign name_byte = cfg_i.name_bytes[{pos_q[3:0], 3'b000} +: 8];
  assign name_byte_ok = (pos_q < 8'(MaxNameBytes)) && (pos_q < 8'(NameSlots)) &&
                        (name_byte == ad_byte_i);

  // UUID bytes arrive low byte first at payload positions 0 and 1
  always_comb begin
    uuid_byte_ok = 1'b1;
    if (pos_q == 8'd0) begin
      uuid_byte_ok = (ad_byte_i == cfg_i.service_uuid[7:0]);
    end else if (pos_q == 8'd1) begin
      uuid_byte_ok = (ad_byte_i == cfg_i.service_uuid[15:8]);
    end
  end

  assign pos_next_plus1 = {1'b0, pos_q} + 9'd2;
  assign name_len_ok    = (len_q == ({3'b000, cfg_i.name_length} + 8'd1));

  // Next state for the accepted byte
  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    type_d      = type_q;
    pos_d       = pos_q;
    name_eq_d   = name_eq_q;
    uuid_eq_d   = uuid_eq_q;
    name_seen_d = name_seen_q;
    svc_seen_d  = svc_seen_q;
    fin         = 1'b0;
    fin_type    = type_q;
    fin_name_eq = name_eq_q;
    fin_uuid_eq = uuid_eq_q;

    unique case (phase_q)
      PhLength: begin
        if (ad_byte_i == 8'd0) begin
          phase_d = PhStopped;
        end else begin
          len_d   = ad_byte_i;
          phase_d = PhType;
        end
      end
      PhType: begin
        type_d      = ad_byte_i;
        pos_d       = 8'd0;
        name_eq_d   = 1'b1;
        uuid_eq_d   = 1'b1;
        fin_type    = ad_byte_i;
        fin_name_eq = 1'b1;
        fin_uuid_eq = 1'b1;
        if (len_q == 8'd1) begin
          fin = 1'b1;
        end else begin
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        name_eq_d   = name_eq_q & name_byte_ok;
        uuid_eq_d   = uuid_eq_q & uuid_byte_ok;
        fin_name_eq = name_eq_d;
        fin_uuid_eq = uuid_eq_d;
        pos_d       = pos_q + 8'd1;
        fin         = (pos_next_plus1 >= {1'b0, len_q});
      end
      PhStopped: begin
      end
      default: begin
      end
    endcase

    // Field complete: judge it and go back to the next length byte
    if (fin) begin
      phase_d = PhLength;
      if (fin_type == TypeCompleteName && name_len_ok && fin_name_eq) begin
        name_seen_d = 1'b1;
      end else if (fin_type == TypeServiceData16 && len_q == ServiceFieldLen &&
                   fin_uuid_eq) begin
        svc_seen_d = 1'b1;
      end
    end
  end

  assign hits_o.name_hit    = name_seen_d;
  assign hits_o.service_hit = svc_seen_d;

  // Parse state; cleared after the packet's last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLength;
      len_q       <= 8'd0;
      type_q      <= 8'd0;
      pos_q       <= 8'd0;
      name_eq_q   <= 1'b1;
      uuid_eq_q   <= 1'b1;
      name_seen_q <= 1'b0;
      svc_seen_q  <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        phase_q     <= PhLength;
        len_q       <= 8'd0;
        type_q      <= 8'd0;
        pos_q       <= 8'd0;
        name_eq_q   <= 1'b1;
        uuid_eq_q   <= 1'b1;
        name_seen_q <= 1'b0;
        svc_seen_q  <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        len_q       <= len_d;
        type_q      <= type_d;
        pos_q       <= pos_d;
        name_eq_q   <= name_eq_d;
        uuid_eq_q   <= uuid_eq_d;
        name_seen_q <= name_seen_d;
        svc_seen_q  <= svc_seen_d;
      end
    end
  end

endmodule

/* rtl/advertising_data_filter_top.sv */
// Advertising data filter: config registers, parser and result register.
// Depends on adf_pkg and adf_parser.
//
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   ad_byte_i, last_byte_i
// out       output     out_valid_o / out_ready_i packet_match_o, name_hit_o, service_hit_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte is taken per cycle; its parse state updates at the accepting edge.
// The verdict for a packet appears in the result register the cycle after its
// last byte is accepted. Input is stalled only while a result is held and
// out_ready_i is low. Reset restores the default UUID and name and clears the
// parse state; configuration writes take effect at the edge that accepts them.
module advertising_data_filter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  ad_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        packet_match_o,
  output logic                        name_hit_o,
  output logic                        service_hit_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [adf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);
  import adf_pkg::*;

  logic [15:0]  uuid_q;
  logic [4:0]   name_len_q;
  logic [31:0]  word0_q, word1_q, word2_q, word3_q;
  filter_cfg_t  cfg;
  filter_hits_t hits;
  logic         in_acc;
  logic         out_valid_q, out_valid_d;
  logic         name_hit_q, svc_hit_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uuid_q     <= RstServiceUuid;
      name_len_q <= RstNameLength;
      word0_q    <= RstNameWord0;
      word1_q    <= RstNameWord1;
      word2_q    <= RstNameWord2;
      word3_q    <= RstNameWord3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgServiceUuid: uuid_q     <= cfg_data_i[15:0];
        CfgNameLength:  name_len_q <= cfg_data_i[4:0];
        CfgNameWord0:   word0_q    <= cfg_data_i;
        CfgNameWord1:   word1_q    <= cfg_data_i;
        CfgNameWord2:   word2_q    <= cfg_data_i;
        CfgNameWord3:   word3_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg.service_uuid = uuid_q;
  assign cfg.name_length  = name_len_q;
  assign cfg.name_bytes   = {word3_q, word2_q, word1_q, word0_q};

  // Byte intake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  adf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .ad_byte_i   (ad_byte_i),
    .last_byte_i (last_byte_i),
    .cfg_i       (cfg),
    .hits_o      (hits)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc && last_byte_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      name_hit_q <= hits.name_hit;
      svc_hit_q  <= hits.service_hit;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign name_hit_o     = name_hit_q;
  assign service_hit_o  = svc_hit_q;
  assign packet_match_o = name_hit_q || svc_hit_q;

  // Checks
  a_match_is_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (packet_match_o == (name_hit_o || service_hit_o)))
    else $error("packet_match differs from OR of hits");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_byte_i) |=> out_valid_o)
    else $error("no result after last byte");

  a_held_result_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while result is blocked");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(in_valid_i && in_ready_o && last_byte_i)) |=> !out_valid_o)
    else $error("result appeared without a last byte");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for advertising_data_filter_top: packet bytes in, verdicts out.
// Depends on adf_pkg and the filter RTL; keeps its own byte-level model of the AD parser.
module tb_top;
  import adf_pkg::*;

  localparam int unsigned WatchdogLimit   = 4000;
  localparam int unsigned DrainCycles     = 10;
  localparam int unsigned CfgSettleCycles = 4;
  localparam int unsigned ItemsPerPhase   = 170;
  localparam int unsigned NumPhases       = 8;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = CfgNameWord3 + 3'd1;

  typedef struct packed {
    logic packet_match;
    logic name_hit;
    logic service_hit;
  } verdict_t;

  // Tracks filter settings and parse state, predicts one verdict per packet
  class verdict_scoreboard;
    logic [15:0]  service_uuid;
    logic [4:0]   name_length;
    logic [127:0] name_bytes;
    phase_e       phase;
    logic [7:0]   field_size;
    logic [7:0]   field_kind;
    int unsigned  pos;
    bit           name_eq, uuid_eq, name_seen, service_seen;
    verdict_t     pending_verdicts[$];
    int unsigned  errors, bytes_seen, verdicts_seen, name_hits, service_hits;

    function new();
      service_uuid = RstServiceUuid;
      name_length  = RstNameLength;
      name_bytes   = {RstNameWord3, RstNameWord2, RstNameWord1, RstNameWord0};
      clear_parse();
    endfunction

    function void clear_parse();
      phase        = PhLength;
      field_size   = '0;
      field_kind   = '0;
      pos          = 0;
      name_eq      = 1'b1;
      uuid_eq      = 1'b1;
      name_seen    = 1'b0;
      service_seen = 1'b0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        CfgServiceUuid: service_uuid = data[15:0];
        CfgNameLength:  name_length = data[4:0];
        CfgNameWord0:   name_bytes[31:0] = data;
        CfgNameWord1:   name_bytes[63:32] = data;
        CfgNameWord2:   name_bytes[95:64] = data;
        CfgNameWord3:   name_bytes[127:96] = data;
        default: ;
      endcase
    endfunction

    // Judge a field once its last byte is in
    function void close_field();
      if (field_kind == TypeCompleteName && field_size == name_length + 1 && name_eq) begin
        name_seen = 1'b1;
      end else if (field_kind == TypeServiceData16 && field_size == ServiceFieldLen &&
                   uuid_eq) begin
        service_seen = 1'b1;
      end
      phase = PhLength;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      verdict_t v;
      bytes_seen++;
      case (phase)
        PhLength: begin
          if (b == 8'h00) phase = PhStopped;
          else begin
            field_size = b;
            phase = PhType;
          end
        end
        PhType: begin
          field_kind = b;
          pos = 0;
          name_eq = 1'b1;
          uuid_eq = 1'b1;
          if (field_size == 8'd1) close_field();
          else phase = PhPayload;
        end
        PhPayload: begin
          // name bytes beyond storage never match
          if (pos >= MaxNameBytes || pos >= 16 || name_bytes[pos*8 +: 8] != b) name_eq = 1'b0;
          if (pos == 0 && b != service_uuid[7:0]) uuid_eq = 1'b0;
          if (pos == 1 && b != service_uuid[15:8]) uuid_eq = 1'b0;
          pos = (pos + 1) & 255;
          if (pos + 1 >= field_size) close_field();
        end
        default: ;
      endcase
      if (last) begin
        v.packet_match = name_seen | service_seen;
        v.name_hit     = name_seen;
        v.service_hit  = service_seen;
        pending_verdicts.push_back(v);
        clear_parse();
      end
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      string    field_name [3];
      field_name = '{"service_hit", "name_hit", "packet_match"};
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t ns: verdict with none expected, expected none actual %b", $time, got);
        return;
      end
      want = pending_verdicts.pop_front();
      verdicts_seen++;
      if (want.name_hit) name_hits++;
      if (want.service_hit) service_hits++;
      for (int i = 0; i < 3; i++) begin
        if (got[i] !== want[i]) begin
          errors++;
          if (errors <= 40) begin
            $display("%0t ns: %s expected %b actual %b", $time, field_name[i], want[i], got[i]);
          end
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid, in_ready;
  logic [7:0]         ad_byte;
  logic               last_byte;
  logic               out_valid, out_ready;
  logic               packet_match, name_hit, service_hit;
  logic               cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  verdict_scoreboard board;
  logic [7:0]        pkt_bytes[$];
  bit                calm;
  int unsigned       idle_cycles;

  advertising_data_filter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .ad_byte_i      (ad_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .packet_match_o (packet_match),
    .name_hit_o     (name_hit),
    .service_hit_o  (service_hit),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Send pkt_bytes, one item per byte, last flag on the final one
  task automatic send_packet();
    int unsigned gap;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      gap = pick_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid  <= 1'b1;
      ad_byte   <= pkt_bytes[i];
      last_byte <= (i == pkt_bytes.size() - 1);
      @(negedge clk_i);
      while (!in_ready) @(negedge clk_i);
      @(posedge clk_i);
      board.note_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    board.set_register(idx, data);
  endtask

  // Quiet input, all verdicts back, then let the parser settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (CfgSettleCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed AD structures built from the current settings, some noise
  task automatic build_packet();
    int unsigned n_fields, kind, flen, flip_at, cut;
    logic [7:0]  fld[$];
    logic        trunc_tail, corrupt;
    pkt_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 32)) pkt_bytes.push_back(8'($urandom));
    end else begin
      n_fields   = $urandom_range(0, 4);
      trunc_tail = ($urandom_range(0, 4) == 0);
      for (int f = 0; f < n_fields + trunc_tail; f++) begin
        kind    = $urandom_range(0, 5);
        corrupt = ($urandom_range(0, 3) == 0);
        fld.delete();
        case (kind)
          0, 1: begin
            // complete-name field, maybe with a wrong length
            flen = board.name_length + 1;
            if (corrupt && $urandom_range(0, 1)) begin
              flen = (flen == 1) ? 2 : ($urandom_range(0, 1) ? flen + 1 : flen - 1);
            end
            fld.push_back(8'(flen));
            fld.push_back(TypeCompleteName);
            for (int j = 0; j + 1 < flen; j++) begin
              fld.push_back(j < 16 ? board.name_bytes[j*8 +: 8] : 8'($urandom));
            end
          end
          2, 3: begin
            // 16-bit service data, maybe with a wrong length
            flen = ServiceFieldLen;
            if (corrupt && $urandom_range(0, 1)) flen = $urandom_range(0, 1) ? 3 : 5;
            fld.push_back(8'(flen));
            fld.push_back(TypeServiceData16);
            for (int j = 0; j + 1 < flen; j++) begin
              fld.push_back(j == 0 ? board.service_uuid[7:0] :
                            j == 1 ? board.service_uuid[15:8] : 8'($urandom));
            end
          end
          default: begin
            flen = $urandom_range(1, 10);
            fld.push_back(8'(flen));
            case ($urandom_range(0, 3))
              0: fld.push_back(TypeCompleteName);
              1: fld.push_back(TypeServiceData16);
              default: fld.push_back(8'($urandom));
            endcase
            repeat (flen - 1) fld.push_back(8'($urandom));
          end
        endcase
        // single bit error in type or payload
        if (corrupt && $urandom_range(0, 1)) begin
          flip_at = $urandom_range(1, fld.size() - 1);
          fld[flip_at] = fld[flip_at] ^ (8'd1 << $urandom_range(0, 7));
        end
        // the tail field is cut short by the end of the packet
        cut = (trunc_tail && f == n_fields) ? $urandom_range(1, fld.size() - 1) : fld.size();
        for (int j = 0; j < cut; j++) pkt_bytes.push_back(fld[j]);
      end
      if (!trunc_tail && $urandom_range(0, 3) == 0) begin
        pkt_bytes.push_back(8'h00);
        repeat ($urandom_range(0, 6)) pkt_bytes.push_back(8'($urandom));
      end
      if (pkt_bytes.size() == 0) pkt_bytes.push_back(8'($urandom));
    end
  endtask

  // Receiver: random ready with stalls of varied length
  initial begin
    int unsigned hold;
    out_ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) hold--;
      else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  // Verdict check and watchdog, sampled mid-cycle where all signals are settled
  initial idle_cycles = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) board.check_verdict({packet_match, name_hit, service_hit});
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [15:0]        uuid;
    logic [4:0]         nlen;
    logic [31:0]        words [4];
    logic [31:0]        cfg_vals [6];
    logic [CfgIdxW-1:0] cfg_order [6];
    int unsigned        sent;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    ad_byte   <= '0;
    last_byte <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CfgServiceUuid;
    cfg_data  <= '0;
    calm      = 1'b0;
    board     = new();
    cfg_order = '{CfgServiceUuid, CfgNameLength, CfgNameWord0, CfgNameWord1, CfgNameWord2,
                  CfgNameWord3};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: service hit
    pkt_bytes = '{8'h04, TypeServiceData16, RstServiceUuid[7:0], RstServiceUuid[15:8], 8'hAA};
    send_packet();
    // zero length stops parsing
    pkt_bytes = '{8'h00, 8'hFF};
    send_packet();
    // one-byte field with an empty payload, then a zero length as last byte
    pkt_bytes = '{8'h01, TypeCompleteName, 8'h00};
    send_packet();
    // packet of a single byte
    pkt_bytes = '{8'hFF};
    send_packet();
    // service field cut off by the packet end
    pkt_bytes = '{8'h04, TypeServiceData16, RstServiceUuid[7:0], RstServiceUuid[15:8]};
    send_packet();
    // empty target name: type-only name field hits, alongside a service hit
    wait_idle();
    write_reg(CfgNameLength, 32'd0);
    cfg_valid <= 1'b0;
    pkt_bytes = '{8'h01, TypeCompleteName, 8'h04, TypeServiceData16, RstServiceUuid[7:0],
                  RstServiceUuid[15:8], 8'h00};
    send_packet();

    // Random packets under a series of filter settings
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      uuid = 16'($urandom);
      nlen = 5'($urandom_range(1, 16));
      for (int w = 0; w < 4; w++) words[w] = $urandom;
      case (p)
        0: begin
          uuid  = RstServiceUuid;
          nlen  = RstNameLength;
          words = '{RstNameWord0, RstNameWord1, RstNameWord2, RstNameWord3};
        end
        1: begin
          uuid  = 16'h0000;
          nlen  = 5'd16;
          words = '{4{32'hFFFF_FFFF}};
        end
        2: begin
          uuid  = 16'hFFFF;
          nlen  = 5'd1;
          words = '{4{32'h0000_0000}};
        end
        3: nlen = 5'd0;
        4: nlen = 5'd17;
        5: nlen = 5'd31;
        default: ;
      endcase
      // upper data bits are junk the block must drop
      cfg_vals = '{{16'($urandom), uuid}, {27'($urandom), nlen}, words[0], words[1], words[2],
                   words[3]};
      for (int r = 0; r < 6; r++) write_reg(cfg_order[r], cfg_vals[r]);
      if (p == 5) write_reg(CfgIdxUnused, $urandom);
      cfg_valid <= 1'b0;
      sent = 0;
      while (sent < ItemsPerPhase) begin
        calm = ($urandom_range(0, 5) == 0);
        build_packet();
        send_packet();
        sent += pkt_bytes.size();
      end
    end

    calm = 1'b0;
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d packet bytes, checked %0d verdicts (%0d name hits, %0d service hits)",
             board.bytes_seen, board.verdicts_seen, board.name_hits, board.service_hits);
    $display("across %0d filter settings with random gaps and stalls on both channels.",
             NumPhases + 2);
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
